// ----- hdl/plis_pkg.sv -----
`default_nettype none
package plis_pkg;

  localparam int unsigned LABEL_W  = 8;
  localparam int unsigned GREY_W   = 16;
  localparam int unsigned SQUARE_W = 2 * GREY_W;
  localparam int unsigned COUNT_W  = 33;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned SQ_W     = 62;

  // queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // one classified item on its way to the back end
  typedef struct packed {
    logic                       op;
    logic                       hit;
    logic [LABEL_W-1:0]         label;
    logic signed [GREY_W-1:0]   grey;
    logic [SQUARE_W-1:0]        square;
  } item_t;

  // one row of the label table
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
    logic [SQ_W-1:0]    sq_sum;
  } entry_t;

endpackage
`default_nettype wire

// ----- hdl/plis_ram.sv -----
`default_nettype none
module plis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/plis_queue.sv -----
`default_nettype none
module plis_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire plis_pkg::item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output plis_pkg::item_t      item_o
);

  localparam int unsigned PTR_W = $clog2(plis_pkg::QUEUE_DEPTH);

  plis_pkg::item_t   slot_q [plis_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]    cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(plis_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q + PTR_W'(do_push);
    rd_d  = rd_q + PTR_W'(do_pop);
    cnt_d = cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/plis_front.sv -----
`default_nettype none
module plis_front #(
  parameter int unsigned LABEL_COUNT = 256,
  parameter int unsigned GREY_BITS   = 16
) (
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                op_i,
  input  wire logic [plis_pkg::LABEL_W-1:0]        label_i,
  input  wire logic signed [plis_pkg::GREY_W-1:0]  grey_i,
  input  wire logic                                q_full_i,
  output logic                                     push_o,
  output plis_pkg::item_t                          item_o
);

  localparam int unsigned PAD = plis_pkg::GREY_W - GREY_BITS;

  logic signed [plis_pkg::GREY_W-1:0]   grey_ext;
  logic signed [plis_pkg::SQUARE_W-1:0] product;

  // keep the low GREY_BITS bits, sign-extend from there
  assign grey_ext = (grey_i <<< PAD) >>> PAD;
  assign product  = grey_ext * grey_ext;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.op     = op_i;
    item_o.hit    = (32'(label_i) < LABEL_COUNT);
    item_o.label  = label_i;
    item_o.grey   = grey_ext;
    item_o.square = unsigned'(product);
  end

endmodule
`default_nettype wire

// ----- hdl/plis_back.sv -----
`default_nettype none
module plis_back #(
  parameter int unsigned LABEL_COUNT = 256
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    q_valid_i,
  input  wire plis_pkg::item_t                         item_i,
  output logic                                         pop_o,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic [plis_pkg::COUNT_W-1:0]                 voxel_count_o,
  output logic signed [plis_pkg::SUM_W-1:0]            grey_sum_o,
  output logic [plis_pkg::SQ_W-1:0]                    grey_square_sum_o
);

  // only labels that fit the 8-bit port can ever be stored
  localparam int unsigned DEPTH = (LABEL_COUNT < (1 << plis_pkg::LABEL_W)) ?
                                  LABEL_COUNT : (1 << plis_pkg::LABEL_W);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EXT_W = plis_pkg::SUM_W - plis_pkg::GREY_W;
  localparam int unsigned SQ_PAD = plis_pkg::SQ_W + 1 - plis_pkg::SQUARE_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state_q, state_d;
  plis_pkg::item_t      item_q;
  logic [DEPTH-1:0]     valid_q;
  logic                 row_valid_q;
  logic [AW-1:0]        rd_addr, cur_addr;
  logic                 ram_we, ram_re, start, out_blocked, finish, load_out;
  plis_pkg::entry_t     ram_rdata, cur, upd;
  logic                 count_full;
  logic [plis_pkg::SQ_W:0] sq_tmp;

  assign rd_addr  = item_i.label[AW-1:0];
  assign cur_addr = item_q.label[AW-1:0];

  assign start = (state_q == ST_IDLE) && q_valid_i;
  assign pop_o = start;
  assign ram_re = start;

  // a read waits here while the previous result is still unclaimed
  assign out_blocked = (item_q.op == plis_pkg::OP_READ) && out_valid_o && !out_ready_i;
  assign finish   = (state_q == ST_EXEC) && !out_blocked;
  assign load_out = finish && (item_q.op == plis_pkg::OP_READ);

  // rows never written since reset read as zero
  assign cur = (row_valid_q && item_q.hit) ? ram_rdata : '0;
  assign count_full = cur.count[plis_pkg::COUNT_W-1];

  always_comb begin
    upd.count = cur.count + plis_pkg::COUNT_W'(1);
    upd.sum   = cur.sum + {{EXT_W{item_q.grey[plis_pkg::GREY_W-1]}}, item_q.grey};
    sq_tmp    = {1'b0, cur.sq_sum} + {{SQ_PAD{1'b0}}, item_q.square};
    upd.sq_sum = sq_tmp[plis_pkg::SQ_W] ? '1 : sq_tmp[plis_pkg::SQ_W-1:0];
  end

  assign ram_we = finish && (item_q.op == plis_pkg::OP_ACCUM) && item_q.hit && !count_full;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_EXEC;
      ST_EXEC: if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        valid_q[cur_addr] <= 1'b1;
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      item_q      <= item_i;
      row_valid_q <= valid_q[rd_addr];
    end
    if (load_out) begin
      voxel_count_o     <= cur.count;
      grey_sum_o        <= signed'(cur.sum);
      grey_square_sum_o <= cur.sq_sum;
    end
  end

  plis_ram #(
    .WIDTH ($bits(plis_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_addr),
    .wdata_i (upd),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire

// ----- hdl/per_label_intensity_statistics_core.sv -----
// A read transfer passes the queue slot, then the back end's item register
// and table read, then the result registers that raise out_valid_o.
// The back end takes one item at a time, through a read-modify-write of
// the label table: it reads a row, then updates and writes it back.
// Reset: asynchronous, active low; per-row valid flops clear the whole table
// at once, so items are accepted in the first cycle after reset.
`default_nettype none
module per_label_intensity_statistics_core #(
  parameter int unsigned LABEL_COUNT = 256,
  parameter int unsigned GREY_BITS   = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // item channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                op_i,
  input  wire logic [plis_pkg::LABEL_W-1:0]        label_i,
  input  wire logic signed [plis_pkg::GREY_W-1:0]  grey_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [plis_pkg::COUNT_W-1:0]             voxel_count_o,
  output logic signed [plis_pkg::SUM_W-1:0]        grey_sum_o,
  output logic [plis_pkg::SQ_W-1:0]                grey_square_sum_o
);

  // Front: classifies the label against the table size, trims the grey
  // value to GREY_BITS and squares it. The product lands in the queue
  // register, so the back end starts from registered operands.
  logic            q_full, q_push, q_valid, q_pop;
  plis_pkg::item_t front_item, back_item;

  plis_front #(
    .LABEL_COUNT (LABEL_COUNT),
    .GREY_BITS   (GREY_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .label_i    (label_i),
    .grey_i     (grey_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .item_o     (front_item)
  );

  // Short queue so input transfers keep flowing while the back end
  // waits on a stalled result.
  plis_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (back_item)
  );

  // Back: one item at a time through the table. Accumulates drop when the
  // count has hit 2^32; the square sum saturates. Reads of labels past the
  // table, or of rows never touched, return zero.
  plis_back #(
    .LABEL_COUNT (LABEL_COUNT)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .item_i            (back_item),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .voxel_count_o     (voxel_count_o),
    .grey_sum_o        (grey_sum_o),
    .grey_square_sum_o (grey_square_sum_o)
  );

endmodule
`default_nettype wire

// ----- sim/tb_per_label_intensity_statistics_core.sv -----
`default_nettype none
module tb_per_label_intensity_statistics_core;

  // Instance settings. With 256 labels every 8-bit label lands in the
  // table, so the "label beyond table" path cannot be reached here. The
  // predictor still models it.
  localparam int unsigned LABEL_COUNT = 256;
  localparam int unsigned GREY_BITS   = 16;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned MAX_GAP      = 11;
  // The result side freezes once, after this many transfers. The item side
  // keeps offering and fills the block's queue.
  localparam int unsigned STALL_AT     = 60;
  localparam int unsigned LONG_HOLD    = 400;
  // Leave some margin before the verdict.
  localparam int unsigned DRAIN_CYCLES = 12;
  // Cycles without any transfer before the run is abandoned. The worst
  // legal quiet stretch is the long hold plus the read latency.
  localparam int unsigned QUIET_LIMIT  = 5000;

  typedef struct {
    logic [plis_pkg::COUNT_W-1:0] count;
    logic [plis_pkg::SUM_W-1:0]   sum;
    logic [plis_pkg::SQ_W-1:0]    sq_sum;
  } label_totals_t;

  // Label table predictor. Every accepted item is applied to its own copy
  // of the per-label totals. A read files the totals it should return,
  // keyed by arrival order.
  class label_totals_predictor;
    logic [plis_pkg::COUNT_W-1:0] count_tab [LABEL_COUNT];
    logic [plis_pkg::SUM_W-1:0]   sum_tab   [LABEL_COUNT];
    logic [plis_pkg::SQ_W-1:0]    sq_tab    [LABEL_COUNT];
    label_totals_t                pending_totals [int unsigned];
    int unsigned                  pend_head;
    int unsigned                  pend_tail;
    int unsigned                  mismatches;

    function new();
      foreach (count_tab[i]) begin
        count_tab[i] = '0;
        sum_tab[i]   = '0;
        sq_tab[i]    = '0;
      end
      pend_head  = 0;
      pend_tail  = 0;
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return pend_tail - pend_head;
    endfunction

    function void note_item(logic op, logic [plis_pkg::LABEL_W-1:0] label,
                            logic [plis_pkg::GREY_W-1:0] grey);
      label_totals_t               t;
      logic [plis_pkg::GREY_W-1:0] raw;
      longint                      g;
      logic [plis_pkg::SQ_W:0]     sq_next;
      bit                          hit;
      int unsigned                 idx;
      idx = label;
      hit = idx < LABEL_COUNT;
      if (op == plis_pkg::OP_READ) begin
        // A label outside the table reads as all zero.
        if (hit) begin
          t.count  = count_tab[idx];
          t.sum    = sum_tab[idx];
          t.sq_sum = sq_tab[idx];
        end else begin
          t.count  = '0;
          t.sum    = '0;
          t.sq_sum = '0;
        end
        pending_totals[pend_tail] = t;
        pend_tail++;
        return;
      end
      // Once the count is full (2^32, the top bit set), voxels are dropped.
      if (!hit || count_tab[idx][plis_pkg::COUNT_W-1]) return;
      // Only the low GREY_BITS bits count, as two's complement.
      raw = grey & plis_pkg::GREY_W'((1 << GREY_BITS) - 1);
      g = raw[GREY_BITS-1] ? longint'(raw) - (longint'(1) << GREY_BITS) : longint'(raw);
      count_tab[idx] = count_tab[idx] + 1'b1;
      sum_tab[idx]   = sum_tab[idx] + plis_pkg::SUM_W'(g);
      // Saturate the square sum at all ones. A carry into the extra bit means
      // the total passed 2^62 - 1.
      sq_next = {1'b0, sq_tab[idx]} + (plis_pkg::SQ_W + 1)'(g * g);
      sq_tab[idx] = sq_next[plis_pkg::SQ_W] ? '1 : sq_next[plis_pkg::SQ_W-1:0];
    endfunction

    function void check_totals(logic [plis_pkg::COUNT_W-1:0] count,
                               logic [plis_pkg::SUM_W-1:0] sum,
                               logic [plis_pkg::SQ_W-1:0] sq_sum);
      label_totals_t want;
      if (pend_tail == pend_head) begin
        $display("%0t: result with no read waiting: count %0d sum %0d square sum %0d",
                 $time, count, $signed(sum), sq_sum);
        mismatches++;
        return;
      end
      want = pending_totals[pend_head];
      pending_totals.delete(pend_head);
      pend_head++;
      if (count !== want.count) begin
        $display("%0t: voxel_count expected %0d, got %0d", $time, want.count, count);
        mismatches++;
      end
      if (sum !== want.sum) begin
        $display("%0t: grey_sum expected %0d, got %0d",
                 $time, $signed(want.sum), $signed(sum));
        mismatches++;
      end
      if (sq_sum !== want.sq_sum) begin
        $display("%0t: grey_square_sum expected %0d, got %0d",
                 $time, want.sq_sum, sq_sum);
        mismatches++;
      end
    endfunction
  endclass

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_ready_o;
  logic                                op_i        = plis_pkg::OP_ACCUM;
  logic [plis_pkg::LABEL_W-1:0]        label_i     = '0;
  logic signed [plis_pkg::GREY_W-1:0]  grey_i      = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic [plis_pkg::COUNT_W-1:0]        voxel_count_o;
  logic signed [plis_pkg::SUM_W-1:0]   grey_sum_o;
  logic [plis_pkg::SQ_W-1:0]           grey_square_sum_o;

  label_totals_predictor board = new();

  // A side in burst mode never idles, bar the one long hold. Each side
  // leaves and enters it at random; gaps and gap-free runs both occur.
  bit          feed_burst  = 1'b0;
  bit          drain_burst = 1'b0;
  int unsigned quiet_cycles = 0;

  per_label_intensity_statistics_core #(
    .LABEL_COUNT (LABEL_COUNT),
    .GREY_BITS   (GREY_BITS)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .label_i           (label_i),
    .grey_i            (grey_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .voxel_count_o     (voxel_count_o),
    .grey_sum_o        (grey_sum_o),
    .grey_square_sum_o (grey_square_sum_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned pick_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Drive one item. The task is entered at a falling edge and returns at
  // the falling edge after its transfer. Valid only drops when a gap is
  // drawn, so back-to-back items keep it high without a glitch.
  task automatic send_item(logic op, logic [plis_pkg::LABEL_W-1:0] label,
                           logic [plis_pkg::GREY_W-1:0] grey);
    int unsigned gap;
    gap = pick_gap(feed_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    label_i    <= label;
    grey_i     <= grey;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Random item. Reads are about one in four. Half of the labels come from a
  // hot set of four, so the same row is often hit on back-to-back items
  // (read-modify-write of one row). Grey values lean toward the extremes.
  task automatic send_random_item();
    logic                         op;
    logic [plis_pkg::LABEL_W-1:0] label;
    logic [plis_pkg::GREY_W-1:0]  grey;
    op = ($urandom_range(0, 3) == 0) ? plis_pkg::OP_READ : plis_pkg::OP_ACCUM;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: label = plis_pkg::LABEL_W'($urandom_range(0, 3));
      5:             label = $urandom_range(0, 1) ? '1 : '0;
      default:       label = plis_pkg::LABEL_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       grey = 16'h8000;
      1:       grey = 16'h7fff;
      2:       grey = 16'hffff;
      3:       grey = 16'h0000;
      default: grey = plis_pkg::GREY_W'($urandom);
    endcase
    send_item(op, label, grey);
  endtask

  // Scoreboard taps at the rising edge. Inputs move on the falling edge,
  // so these samples are stable.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_item(op_i, label_i, grey_i);
      if (out_valid_o && out_ready_i)
        board.check_totals(voxel_count_o, grey_sum_o, grey_square_sum_o);
    end
  end

  // Watchdog on progress: any transfer on either channel resets it.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. Idles at random before each transfer, and holds off once
  // for a long stretch to back the block up.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 32 == 0) drain_burst = ($urandom_range(0, 2) == 0);
      gap = (taken == STALL_AT) ? LONG_HOLD : pick_gap(drain_burst);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : item_source
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Fresh rows read as zero.
    send_item(plis_pkg::OP_READ,  8'd0,   16'h1234);
    send_item(plis_pkg::OP_READ,  8'd255, 16'hffff);
    // Grey extremes into row 0, then read it as the next item.
    send_item(plis_pkg::OP_ACCUM, 8'd0,   16'h8000);
    send_item(plis_pkg::OP_ACCUM, 8'd0,   16'h7fff);
    send_item(plis_pkg::OP_ACCUM, 8'd0,   16'h0000);
    send_item(plis_pkg::OP_ACCUM, 8'd0,   16'hffff);
    send_item(plis_pkg::OP_READ,  8'd0,   16'h0000);
    // Largest square twice into the top row, so the sum goes negative.
    send_item(plis_pkg::OP_ACCUM, 8'd255, 16'h8000);
    send_item(plis_pkg::OP_ACCUM, 8'd255, 16'h8000);
    send_item(plis_pkg::OP_READ,  8'd255, 16'h5555);
    // Reads interleaved with updates of the same row.
    send_item(plis_pkg::OP_ACCUM, 8'd7,   16'h0001);
    send_item(plis_pkg::OP_READ,  8'd7,   16'haaaa);
    send_item(plis_pkg::OP_ACCUM, 8'd7,   16'hfffe);
    send_item(plis_pkg::OP_READ,  8'd7,   16'h0000);
    // Alternating rows, then both read back.
    send_item(plis_pkg::OP_ACCUM, 8'd170, 16'h5555);
    send_item(plis_pkg::OP_ACCUM, 8'd85,  16'haaaa);
    send_item(plis_pkg::OP_ACCUM, 8'd170, 16'h7fff);
    send_item(plis_pkg::OP_READ,  8'd170, 16'h0000);
    send_item(plis_pkg::OP_READ,  8'd85,  16'h0000);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) feed_burst = ($urandom_range(0, 2) == 0);
      send_random_item();
    end
    in_valid_i <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
